>>> design/qre_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qre_pkg
// shared codes and control types of the quadratic roots and extrema unit
// ---------------------------------------------------------------------------
package qre_pkg;

  // request codes; code 3 is decoded as a cubic request
  typedef enum logic [1:0] {
    REQ_ROOTS  = 2'd0,
    REQ_VERTEX = 2'd1,
    REQ_CUBIC  = 2'd2
  } req_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NEG_DISC  = 2'd1,
    ST_ZERO_LEAD = 2'd2,
    ST_SAT       = 2'd3
  } status_e;

  // classification that travels with each request
  typedef struct packed {
    req_e kind;
    logic c3_pos;
    logic a_zero;
    logic d_neg;
  } ctl_t;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

endpackage

>>> design/qre_req_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qre_req_if
// request channel: request code and four fixed point coefficients
// ---------------------------------------------------------------------------
interface qre_req_if #(
  parameter int unsigned COEF_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic signed [COEF_WIDTH-1:0] coef_0;
  logic signed [COEF_WIDTH-1:0] coef_1;
  logic signed [COEF_WIDTH-1:0] coef_2;
  logic signed [COEF_WIDTH-1:0] coef_3;

  modport source (output valid, req_type, coef_0, coef_1, coef_2, coef_3, input ready);
  modport sink (input valid, req_type, coef_0, coef_1, coef_2, coef_3, output ready);
endinterface

>>> design/qre_rsp_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qre_rsp_if
// result channel: two points and a status code
// ---------------------------------------------------------------------------
interface qre_rsp_if #(
  parameter int unsigned COEF_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [COEF_WIDTH-1:0] first_point;
  logic signed [COEF_WIDTH-1:0] second_point;
  logic [1:0]                   status;

  modport source (output valid, first_point, second_point, status, input ready);
  modport sink (input valid, first_point, second_point, status, output ready);
endinterface

>>> design/qre_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qre_front
// accepts requests, picks the quadratic to solve and forms its discriminant
// ---------------------------------------------------------------------------
module qre_front #(
  parameter int unsigned COEF_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  qre_req_if.sink                            req_i,
  input  logic                               full_i,
  output logic                               push_o,
  output qre_pkg::ctl_t                      ctl_o,
  output logic signed [COEF_WIDTH+1:0]       a_o,
  output logic signed [COEF_WIDTH+1:0]       b_o,
  output logic [2*COEF_WIDTH+5:0]            d_o
);
  import qre_pkg::*;

  localparam int unsigned W  = COEF_WIDTH;
  localparam int unsigned AW = W + 2;
  localparam int unsigned MW = W + 1;
  localparam int unsigned PW = 2 * MW;
  localparam int unsigned DW = 2 * W + 6;

  logic en;

  // stage a: classification
  logic                 va_q;
  ctl_t                 ctl_a_d, ctl_a_q;
  logic signed [AW-1:0] a_d, b_d, c_d, a_a_q, b_a_q, c_a_q;
  logic signed [AW-1:0] c0_x, c1_x, c2_x, c3_x;

  // stage b: products
  logic                 vb_q;
  ctl_t                 ctl_b_q;
  logic signed [AW-1:0] a_b_q, b_b_q;
  logic [MW-1:0]        a_mag, b_mag, c_mag;
  logic [PW-1:0]        bsq_q, ac_q;
  logic                 acneg_q;

  // stage c: discriminant
  logic                 vc_q;
  ctl_t                 ctl_c_d, ctl_c_q;
  logic signed [AW-1:0] a_c_q, b_c_q;
  logic [DW-1:0]        d_d, d_c_q, bsq_x, ac4_x;

  // the whole front stalls only when its last stage cannot enter the queue
  assign en          = !(vc_q && full_i);
  assign req_i.ready = en;

  assign c0_x = AW'(req_i.coef_0);
  assign c1_x = AW'(req_i.coef_1);
  assign c2_x = AW'(req_i.coef_2);
  assign c3_x = AW'(req_i.coef_3);

  // request decode
  always_comb begin
    ctl_a_d = '0;
    unique case (req_i.req_type)
      REQ_ROOTS: begin
        a_d          = c2_x;
        b_d          = c1_x;
        c_d          = c0_x;
        ctl_a_d.kind = REQ_ROOTS;
      end
      REQ_VERTEX: begin
        a_d          = c2_x;
        b_d          = c1_x;
        c_d          = '0;
        ctl_a_d.kind = REQ_VERTEX;
      end
      default: begin
        a_d          = (c3_x <<< 1) + c3_x;
        b_d          = c2_x <<< 1;
        c_d          = c1_x;
        ctl_a_d.kind = REQ_CUBIC;
      end
    endcase
    ctl_a_d.c3_pos = req_i.coef_3 > 0;
    ctl_a_d.a_zero = a_d == '0;
  end

  // magnitudes for the unsigned products
  assign a_mag = MW'(a_a_q[AW-1] ? -a_a_q : a_a_q);
  assign b_mag = MW'(b_a_q[AW-1] ? -b_a_q : b_a_q);
  assign c_mag = MW'(c_a_q[AW-1] ? -c_a_q : c_a_q);

  // b*b - 4*a*c in sign and magnitude
  assign bsq_x = DW'(bsq_q);
  assign ac4_x = DW'({ac_q, 2'b00});

  always_comb begin
    ctl_c_d = ctl_b_q;
    if (acneg_q) begin
      d_d = bsq_x + ac4_x;
    end else if (bsq_x >= ac4_x) begin
      d_d = bsq_x - ac4_x;
    end else begin
      d_d           = '0;
      ctl_c_d.d_neg = 1'b1;
    end
  end

  // stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en) begin
      va_q <= req_i.valid;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      ctl_a_q <= ctl_a_d;
      a_a_q   <= a_d;
      b_a_q   <= b_d;
      c_a_q   <= c_d;
      ctl_b_q <= ctl_a_q;
      a_b_q   <= a_a_q;
      b_b_q   <= b_a_q;
      bsq_q   <= PW'(b_mag) * PW'(b_mag);
      ac_q    <= PW'(a_mag) * PW'(c_mag);
      acneg_q <= a_a_q[AW-1] ^ c_a_q[AW-1];
      ctl_c_q <= ctl_c_d;
      a_c_q   <= a_b_q;
      b_c_q   <= b_b_q;
      d_c_q   <= d_d;
    end
  end

  assign push_o = vc_q && !full_i;
  assign ctl_o  = ctl_c_q;
  assign a_o    = a_c_q;
  assign b_o    = b_c_q;
  assign d_o    = d_c_q;

endmodule

>>> design/qre_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qre_fifo
// short queue that decouples the front from the back
// ---------------------------------------------------------------------------
module qre_fifo #(
  parameter int unsigned DATA_WIDTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [DATA_WIDTH-1:0] data_i,
  input  logic                  pop_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  full_o,
  output logic                  empty_o
);
  import qre_pkg::*;

  localparam int unsigned PTRW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNTW = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PTRW-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [CNTW-1:0]       cnt_q, cnt_d;

  // pointer and fill count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTRW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PTRW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_q];
  assign full_o  = cnt_q == CNTW'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;

  // queue bookkeeping checks
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from an empty queue");
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("fill count lost a push");

endmodule

>>> design/qre_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qre_div
// pipelined restoring unsigned divider, one quotient bit per stage
// ---------------------------------------------------------------------------
module qre_div #(
  parameter int unsigned DVD_WIDTH = 52,
  parameter int unsigned DVS_WIDTH = 34
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [DVD_WIDTH-1:0] dvd_i,
  input  logic [DVS_WIDTH-1:0] dvs_i,
  output logic [DVD_WIDTH-1:0] quo_o
);

  // dq holds the dividend bits still to come, with quotient bits shifting in
  logic [DVD_WIDTH-1:0] dq_q  [DVD_WIDTH];
  logic [DVS_WIDTH-1:0] rem_q [DVD_WIDTH];
  logic [DVS_WIDTH-1:0] dvs_q [DVD_WIDTH];

  for (genvar k = 0; k < DVD_WIDTH; k++) begin : g_stage
    logic [DVD_WIDTH-1:0] dq_in;
    logic [DVS_WIDTH-1:0] rem_in, dvs_in;
    logic [DVS_WIDTH:0]   trial;
    logic                 take;

    if (k == 0) begin : g_first
      assign dq_in  = dvd_i;
      assign rem_in = '0;
      assign dvs_in = dvs_i;
    end else begin : g_next
      assign dq_in  = dq_q[k-1];
      assign rem_in = rem_q[k-1];
      assign dvs_in = dvs_q[k-1];
    end

    // shift in the next dividend bit and try the subtraction
    assign trial = {rem_in, dq_in[DVD_WIDTH-1]};
    assign take  = trial >= {1'b0, dvs_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dq_q[k]  <= {dq_in[DVD_WIDTH-2:0], take};
        rem_q[k] <= take ? DVS_WIDTH'(trial - {1'b0, dvs_in}) : DVS_WIDTH'(trial);
        dvs_q[k] <= dvs_in;
      end
    end
  end

  assign quo_o = dq_q[DVD_WIDTH-1];

endmodule

>>> design/qre_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qre_back
// square root, two quotients, saturation, ordering and the result register
// ---------------------------------------------------------------------------
module qre_back #(
  parameter int unsigned COEF_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               empty_i,
  input  qre_pkg::ctl_t                      ctl_i,
  input  logic signed [COEF_WIDTH+1:0]       a_i,
  input  logic signed [COEF_WIDTH+1:0]       b_i,
  input  logic [2*COEF_WIDTH+5:0]            d_i,
  output logic                               pop_o,
  qre_rsp_if.source                          rsp_o
);
  import qre_pkg::*;

  localparam int unsigned W   = COEF_WIDTH;
  localparam int unsigned AW  = W + 2;
  localparam int unsigned MW  = W + 1;
  localparam int unsigned DW  = 2 * W + 6;
  localparam int unsigned SW  = DW / 2;
  localparam int unsigned RW  = SW + 1;
  localparam int unsigned NW  = W + 5;
  localparam int unsigned QW  = NW - 1 + FRAC_BITS;
  localparam int unsigned DVW = W + 2;

  logic en;

  // square root pipeline, stage 0 holds the queue head
  logic [SW:0]          sv_q;
  ctl_t                 sctl_q  [SW+1];
  logic signed [AW-1:0] sa_q    [SW+1];
  logic signed [AW-1:0] sb_q    [SW+1];
  logic [DW-1:0]        sd_q    [SW+1];
  logic [SW-1:0]        sroot_q [SW+1];
  logic [RW-1:0]        srem_q  [SW+1];

  // numerator stage
  logic                 nv_q;
  ctl_t                 nctl_q;
  logic                 nneg1_q, nneg2_q;
  logic [QW-1:0]        dvd1_q, dvd2_q;
  logic [DVW-1:0]       dvs_q;
  logic signed [NW-1:0] s_x, b_x, n1, n2;
  logic [MW-1:0]        a_mag;

  // side band that runs alongside the dividers
  logic [QW-1:0]        mv_q;
  ctl_t                 mctl_q  [QW];
  logic                 mneg1_q [QW];
  logic                 mneg2_q [QW];
  logic [QW-1:0]        quo1, quo2;

  // result register
  logic                 out_v_q;
  logic signed [W-1:0]  first_d, first_q, second_d, second_q;
  status_e              status_d, status_q;
  logic [W-1:0]         lim_pos, lim1, lim2, mag1, mag2;
  logic                 sat1, sat2;
  logic signed [W-1:0]  val1, val2, lo, hi;
  ctl_t                 fctl;

  // the back moves as one whenever the result register can take a result
  assign en    = !out_v_q || rsp_o.ready;
  assign pop_o = en && !empty_i;

  // queue head enters stage 0
  always_ff @(posedge clk_i) begin
    if (en) begin
      sctl_q[0]  <= ctl_i;
      sa_q[0]    <= a_i;
      sb_q[0]    <= b_i;
      sd_q[0]    <= d_i;
      sroot_q[0] <= '0;
      srem_q[0]  <= '0;
    end
  end

  // floor square root, one root bit per stage
  for (genvar k = 1; k <= SW; k++) begin : g_sqrt
    logic [RW+1:0] rs, trial;
    logic          take;

    assign rs    = {srem_q[k-1], sd_q[k-1][DW-1 -: 2]};
    assign trial = (RW+2)'({sroot_q[k-1], 2'b01});
    assign take  = rs >= trial;

    always_ff @(posedge clk_i) begin
      if (en) begin
        sctl_q[k]  <= sctl_q[k-1];
        sa_q[k]    <= sa_q[k-1];
        sb_q[k]    <= sb_q[k-1];
        sd_q[k]    <= {sd_q[k-1][DW-3:0], 2'b00};
        sroot_q[k] <= {sroot_q[k-1][SW-2:0], take};
        srem_q[k]  <= take ? RW'(rs - trial) : RW'(rs);
      end
    end
  end

  // numerators -b - s and -b + s, denominator 2a; a vertex uses s = 0
  assign s_x   = (sctl_q[SW].kind == REQ_VERTEX) ? '0 : NW'(sroot_q[SW]);
  assign b_x   = NW'(sb_q[SW]);
  assign n1    = -b_x - s_x;
  assign n2    = -b_x + s_x;
  assign a_mag = MW'(sa_q[SW][AW-1] ? -sa_q[SW] : sa_q[SW]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      nctl_q  <= sctl_q[SW];
      nneg1_q <= n1[NW-1] ^ sa_q[SW][AW-1];
      nneg2_q <= n2[NW-1] ^ sa_q[SW][AW-1];
      dvd1_q  <= {(NW-1)'(n1[NW-1] ? -n1 : n1), {FRAC_BITS{1'b0}}};
      dvd2_q  <= {(NW-1)'(n2[NW-1] ? -n2 : n2), {FRAC_BITS{1'b0}}};
      dvs_q   <= {a_mag, 1'b0};
    end
  end

  qre_div #(
    .DVD_WIDTH(QW),
    .DVS_WIDTH(DVW)
  ) u_div_lo (
    .clk_i(clk_i),
    .en_i (en),
    .dvd_i(dvd1_q),
    .dvs_i(dvs_q),
    .quo_o(quo1)
  );

  qre_div #(
    .DVD_WIDTH(QW),
    .DVS_WIDTH(DVW)
  ) u_div_hi (
    .clk_i(clk_i),
    .en_i (en),
    .dvd_i(dvd2_q),
    .dvs_i(dvs_q),
    .quo_o(quo2)
  );

  // side band delay matching the dividers
  for (genvar k = 0; k < QW; k++) begin : g_side
    if (k == 0) begin : g_head
      always_ff @(posedge clk_i) begin
        if (en) begin
          mctl_q[k]  <= nctl_q;
          mneg1_q[k] <= nneg1_q;
          mneg2_q[k] <= nneg2_q;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en) begin
          mctl_q[k]  <= mctl_q[k-1];
          mneg1_q[k] <= mneg1_q[k-1];
          mneg2_q[k] <= mneg2_q[k-1];
        end
      end
    end
  end

  // valid flags of every stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q    <= '0;
      nv_q    <= 1'b0;
      mv_q    <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      sv_q    <= {sv_q[SW-1:0], !empty_i};
      nv_q    <= sv_q[SW];
      mv_q    <= {mv_q[QW-2:0], nv_q};
      out_v_q <= mv_q[QW-1];
    end
  end

  // saturation to the signed coefficient range
  assign fctl    = mctl_q[QW-1];
  assign lim_pos = {1'b0, {(W-1){1'b1}}};
  assign lim1    = lim_pos + W'(mneg1_q[QW-1]);
  assign lim2    = lim_pos + W'(mneg2_q[QW-1]);
  assign sat1    = quo1 > QW'(lim1);
  assign sat2    = quo2 > QW'(lim2);
  assign mag1    = sat1 ? lim1 : quo1[W-1:0];
  assign mag2    = sat2 ? lim2 : quo2[W-1:0];
  assign val1    = mneg1_q[QW-1] ? -mag1 : mag1;
  assign val2    = mneg2_q[QW-1] ? -mag2 : mag2;
  assign lo      = (val1 > val2) ? val2 : val1;
  assign hi      = (val1 > val2) ? val1 : val2;

  // status precedence and point order
  always_comb begin
    first_d  = '0;
    second_d = '0;
    status_d = ST_OK;
    if (fctl.a_zero) begin
      status_d = ST_ZERO_LEAD;
    end else if (fctl.kind == REQ_VERTEX) begin
      first_d  = val1;
      status_d = sat1 ? ST_SAT : ST_OK;
    end else if (fctl.d_neg) begin
      status_d = ST_NEG_DISC;
    end else begin
      if (fctl.kind == REQ_CUBIC && fctl.c3_pos) begin
        first_d  = hi;
        second_d = lo;
      end else begin
        first_d  = lo;
        second_d = hi;
      end
      status_d = (sat1 || sat2) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      first_q  <= first_d;
      second_q <= second_d;
      status_q <= status_d;
    end
  end

  assign rsp_o.valid        = out_v_q;
  assign rsp_o.first_point  = first_q;
  assign rsp_o.second_point = second_q;
  assign rsp_o.status       = status_q;

  // error results carry zero points
  a_zero_lead_pts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && status_q == ST_ZERO_LEAD) |-> (first_q == '0 && second_q == '0))
    else $error("zero leading coefficient with nonzero points");
  a_neg_disc_pts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && status_q == ST_NEG_DISC) |-> (first_q == '0 && second_q == '0))
    else $error("negative discriminant with nonzero points");
  // a stalled result stays put
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !rsp_o.ready) |=>
      (out_v_q && $stable(first_q) && $stable(second_q) && $stable(status_q)))
    else $error("result changed while stalled");

endmodule

>>> design/quadratic_roots_and_extrema_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quadratic_roots_and_extrema_unit
// real roots, vertex and cubic stationary points in signed fixed point
// ---------------------------------------------------------------------------
// Usage
//   req_i carries a request code and four signed fixed point coefficients,
//   rsp_o one result per request: two points and a status code. Both are
//   valid/ready channels; a transaction completes when valid and ready are
//   high at a rising edge. Results leave in request order.
//   Throughput: one request per cycle for as long as rsp_o is ready.
//   Path: the front stages (classify, products, discriminant), the queue,
//   then 1 + (2*COEF_WIDTH+6)/2 square root stages,
//   one numerator stage, COEF_WIDTH+4+FRAC_BITS divider stages and the
//   result register; the square root and quotient pipelines each make
//   one bit per stage.
//   A stalled rsp_o freezes the back part only; the front keeps taking
//   requests until the 4-entry queue fills, then drops req_i.ready.
//   Reset clears all valid flags and the queue; no results are pending after.
// ---------------------------------------------------------------------------
module quadratic_roots_and_extrema_unit #(
  parameter int unsigned COEF_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  qre_req_if.sink    req_i,
  qre_rsp_if.source  rsp_o
);
  import qre_pkg::*;

  localparam int unsigned AW = COEF_WIDTH + 2;
  localparam int unsigned DW = 2 * COEF_WIDTH + 6;
  localparam int unsigned EW = $bits(ctl_t) + 2 * AW + DW;

  logic                 push, pop, full, empty;
  ctl_t                 f_ctl, b_ctl;
  logic signed [AW-1:0] f_a, f_b, b_a, b_b;
  logic [DW-1:0]        f_d, b_d;
  logic [EW-1:0]        q_in, q_out;

  // front: decode and discriminant
  qre_front #(
    .COEF_WIDTH(COEF_WIDTH)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .full_i(full),
    .push_o(push),
    .ctl_o (f_ctl),
    .a_o   (f_a),
    .b_o   (f_b),
    .d_o   (f_d)
  );

  // queue between front and back
  assign q_in = {f_ctl, f_a, f_b, f_d};

  qre_fifo #(
    .DATA_WIDTH(EW)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (q_in),
    .pop_i  (pop),
    .data_o (q_out),
    .full_o (full),
    .empty_o(empty)
  );

  assign {b_ctl, b_a, b_b, b_d} = q_out;

  // back: root, quotients and result
  qre_back #(
    .COEF_WIDTH(COEF_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .empty_i(empty),
    .ctl_i  (b_ctl),
    .a_i    (b_a),
    .b_i    (b_b),
    .d_i    (b_d),
    .pop_o  (pop),
    .rsp_o  (rsp_o)
  );

endmodule
